// ----- rtl/core/elgd_pkg.sv -----
package elgd_pkg;

   localparam int NUM_CARS_DEF   = 8;
   localparam int FLOOR_BITS_DEF = 6;
   localparam int LOAD_BITS_DEF  = 8;

   localparam int PENALTY_W = 4;
   localparam logic [PENALTY_W-1:0] PENALTY_RESET = 4'd2;

   localparam logic [1:0] ACT_STATUS  = 2'd0;
   localparam logic [1:0] ACT_FAULT   = 2'd1;
   localparam logic [1:0] ACT_REQUEST = 2'd2;

   typedef struct packed {
      logic [1:0] action;
      logic [2:0] car_id;
      logic [5:0] floor;
      logic       going_up;
   } req_type;

   typedef struct packed {
      logic       assign_found;
      logic [2:0] assigned_car;
      logic       reached;
      logic       car_moving;
   } rsp_type;

   typedef struct packed {
      logic known;
      logic faulty;
      logic moving;
      logic dir_known;
      logic dir_up;
   } car_flags_type;

endpackage

// ----- rtl/core/elgd_car_table.sv -----
module elgd_car_table
   import elgd_pkg::*;
#(
   parameter int NUM_CARS   = NUM_CARS_DEF,
   parameter int FLOOR_BITS = FLOOR_BITS_DEF,
   parameter int LOAD_BITS  = LOAD_BITS_DEF,
   localparam int IDX_BITS  = (NUM_CARS > 1) ? $clog2(NUM_CARS) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  rd_en,
   input  logic [IDX_BITS-1:0]   rd_addr,
   output car_flags_type         rd_flags,
   output logic [FLOOR_BITS-1:0] rd_floor,
   output logic [LOAD_BITS-1:0]  rd_load,
   input  logic                  wr_en,
   input  logic [IDX_BITS-1:0]   wr_addr,
   input  car_flags_type         wr_flags,
   input  logic [FLOOR_BITS-1:0] wr_floor,
   input  logic [LOAD_BITS-1:0]  wr_load
);

   localparam int WORD_W = $bits(car_flags_type) + FLOOR_BITS + LOAD_BITS;

   logic [WORD_W-1:0]   mem_ff [NUM_CARS];
   logic [WORD_W-1:0]   rd_word_ff;
   logic                rd_hit_ff;
   logic                rd_hit_in;
   logic [NUM_CARS-1:0] valid_ff;
   logic [NUM_CARS-1:0] valid_in;

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
      rd_hit_in = rd_hit_ff;
      if (rd_en) begin
         rd_hit_in = valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= {wr_flags, wr_floor, wr_load};
      end
      if (rd_en) begin
         rd_word_ff <= mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rd_hit_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         rd_hit_ff <= rd_hit_in;
      end
   end

   // an entry never written reads as the cleared value
   assign {rd_flags, rd_floor, rd_load} = rd_hit_ff ? rd_word_ff : '0;

endmodule

// ----- rtl/core/elgd_ctrl.sv -----
module elgd_ctrl
   import elgd_pkg::*;
#(
   parameter int NUM_CARS   = NUM_CARS_DEF,
   parameter int FLOOR_BITS = FLOOR_BITS_DEF,
   parameter int LOAD_BITS  = LOAD_BITS_DEF,
   localparam int IDX_BITS  = (NUM_CARS > 1) ? $clog2(NUM_CARS) : 1
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   input  logic [PENALTY_W-1:0]  penalty,
   output logic                  fin_valid,
   input  logic                  fin_ready,
   output rsp_type               fin_data,
   output logic                  rd_en,
   output logic [IDX_BITS-1:0]   rd_addr,
   input  car_flags_type         rd_flags,
   input  logic [FLOOR_BITS-1:0] rd_floor,
   input  logic [LOAD_BITS-1:0]  rd_load,
   output logic                  wr_en,
   output logic [IDX_BITS-1:0]   wr_addr,
   output car_flags_type         wr_flags,
   output logic [FLOOR_BITS-1:0] wr_floor,
   output logic [LOAD_BITS-1:0]  wr_load
);

   localparam int CNT_W  = $clog2(NUM_CARS + 1);
   localparam int DIST_W = ((FLOOR_BITS > PENALTY_W) ? FLOOR_BITS : PENALTY_W) + 1;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_CARS);
   localparam logic [LOAD_BITS-1:0] LOAD_MAX = {LOAD_BITS{1'b1}};

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_UPDATE = 3'd1;
   localparam logic [2:0] ST_SCAN   = 3'd2;
   localparam logic [2:0] ST_COMMIT = 3'd3;
   localparam logic [2:0] ST_FINISH = 3'd4;

   logic [2:0]            state_ff, state_in;
   req_type               item_ff, item_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  pend_ff, pend_in;
   logic [IDX_BITS-1:0]   eval_idx_ff, eval_idx_in;
   logic                  found_ff, found_in;
   logic [IDX_BITS-1:0]   best_idx_ff, best_idx_in;
   car_flags_type         best_flags_ff, best_flags_in;
   logic [FLOOR_BITS-1:0] best_floor_ff, best_floor_in;
   logic [LOAD_BITS-1:0]  best_load_ff, best_load_in;
   logic [DIST_W-1:0]     best_dist_ff, best_dist_in;
   rsp_type               res_ff, res_in;

   logic                  req_fire;
   logic                  req_id_ok;
   logic [FLOOR_BITS-1:0] item_floor;
   logic [FLOOR_BITS-1:0] abs_dist;
   logic [DIST_W-1:0]     cand_dist;
   logic                  take;

   assign req_fire   = req_valid && req_ready;
   assign req_id_ok  = (32'(req_data.car_id) < NUM_CARS);
   assign item_floor = FLOOR_BITS'(item_ff.floor);

   // distance of the car whose entry is on the read port
   always_comb begin
      abs_dist  = (rd_floor > item_floor) ? (rd_floor - item_floor) : (item_floor - rd_floor);
      cand_dist = DIST_W'(abs_dist);
      if (rd_flags.dir_known && (rd_flags.dir_up != item_ff.going_up)) begin
         cand_dist = DIST_W'(abs_dist) + DIST_W'(penalty);
      end
      take = rd_flags.known && !rd_flags.faulty &&
             (!found_ff || (rd_load < best_load_ff) ||
              ((rd_load == best_load_ff) && (cand_dist < best_dist_ff)));
   end

   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      cnt_in        = cnt_ff;
      pend_in       = 1'b0;
      eval_idx_in   = eval_idx_ff;
      found_in      = found_ff;
      best_idx_in   = best_idx_ff;
      best_flags_in = best_flags_ff;
      best_floor_in = best_floor_ff;
      best_load_in  = best_load_ff;
      best_dist_in  = best_dist_ff;
      res_in        = res_ff;
      req_ready     = 1'b0;
      fin_valid     = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = '0;
      wr_en         = 1'b0;
      wr_addr       = IDX_BITS'(item_ff.car_id);
      wr_flags      = rd_flags;
      wr_floor      = rd_floor;
      wr_load       = rd_load;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_fire) begin
               item_in = req_data;
               if (req_data.action == ACT_REQUEST) begin
                  cnt_in      = '0;
                  found_in    = 1'b0;
                  best_idx_in = '0;
                  state_in    = ST_SCAN;
               end else if (((req_data.action == ACT_STATUS) ||
                             (req_data.action == ACT_FAULT)) && req_id_ok) begin
                  rd_en    = 1'b1;
                  rd_addr  = IDX_BITS'(req_data.car_id);
                  state_in = ST_UPDATE;
               end else begin
                  res_in   = '0;
                  state_in = ST_FINISH;
               end
            end
         end

         ST_UPDATE: begin
            wr_en  = 1'b1;
            res_in = '0;
            if (item_ff.action == ACT_STATUS) begin
               wr_flags.known = 1'b1;
               wr_floor       = item_floor;
               if (rd_flags.known) begin
                  if (rd_floor != item_floor) begin
                     wr_flags.moving = 1'b1;
                  end else if (rd_flags.moving) begin
                     wr_flags.moving = 1'b0;
                     res_in.reached  = 1'b1;
                  end
               end
               res_in.car_moving = wr_flags.moving;
            end else begin
               wr_flags.faulty   = 1'b1;
               res_in.car_moving = rd_flags.moving;
            end
            state_in = ST_FINISH;
         end

         ST_SCAN: begin
            // issue the next read while judging the entry read last cycle
            if (cnt_ff != CNT_LAST) begin
               rd_en       = 1'b1;
               rd_addr     = cnt_ff[IDX_BITS-1:0];
               eval_idx_in = cnt_ff[IDX_BITS-1:0];
               pend_in     = 1'b1;
               cnt_in      = cnt_ff + CNT_W'(1);
            end
            if (pend_ff && take) begin
               found_in      = 1'b1;
               best_idx_in   = eval_idx_ff;
               best_flags_in = rd_flags;
               best_floor_in = rd_floor;
               best_load_in  = rd_load;
               best_dist_in  = cand_dist;
            end
            if (cnt_ff == CNT_LAST) begin
               state_in = ST_COMMIT;
            end
         end

         ST_COMMIT: begin
            wr_en              = found_ff;
            wr_addr            = best_idx_ff;
            wr_flags           = best_flags_ff;
            wr_flags.dir_known = 1'b1;
            wr_flags.dir_up    = item_ff.going_up;
            wr_floor           = best_floor_ff;
            wr_load            = (best_load_ff != LOAD_MAX) ?
                                 (best_load_ff + LOAD_BITS'(1)) : best_load_ff;
            res_in              = '0;
            res_in.assign_found = found_ff;
            res_in.assigned_car = 3'(best_idx_ff);
            state_in            = ST_FINISH;
         end

         ST_FINISH: begin
            fin_valid = 1'b1;
            if (fin_ready) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pend_ff  <= 1'b0;
         cnt_ff   <= '0;
         found_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         cnt_ff   <= cnt_in;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff       <= item_in;
      eval_idx_ff   <= eval_idx_in;
      best_idx_ff   <= best_idx_in;
      best_flags_ff <= best_flags_in;
      best_floor_ff <= best_floor_in;
      best_load_ff  <= best_load_in;
      best_dist_ff  <= best_dist_in;
      res_ff        <= res_in;
   end

   assign fin_data = res_ff;

   a_no_rd_wr_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rd_en && wr_en))
      else $error("table read and write in the same cycle");

   a_one_item_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ready)
      else $error("new beat taken while an item is in flight");

   a_commit_load_nonzero: assert property (@(posedge clock) disable iff (reset)
      (wr_en && (state_ff == ST_COMMIT)) |-> (wr_load != '0))
      else $error("assigned car load wrapped to zero");

   a_no_assign_on_status: assert property (@(posedge clock) disable iff (reset)
      (fin_valid && (item_ff.action != ACT_REQUEST)) |-> !fin_data.assign_found)
      else $error("assignment reported for a non-request beat");

endmodule

// ----- rtl/core/elevator_group_dispatcher_unit.sv -----
// Elevator group dispatcher. The car table (known floor, fault, motion, last
// direction, load) sits in one synchronous memory with a single read and a
// single write port, and the block handles one beat at a time. A status or
// fault beat goes from acceptance through a read, a write back and a hand
// off to the result register; a hall request walks over every car through
// the one read port, then writes back the chosen car (if one is found) and
// hands off its result. A finished result waits in an output register, so
// the next beat is taken while the previous result is still pending. The
// penalty register may only be written while idle.
module elevator_group_dispatcher_unit
   import elgd_pkg::*;
#(
   parameter int NUM_CARS   = NUM_CARS_DEF,
   parameter int FLOOR_BITS = FLOOR_BITS_DEF,
   parameter int LOAD_BITS  = LOAD_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_type              rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [PENALTY_W-1:0] csr_data
);

   localparam int IDX_BITS = (NUM_CARS > 1) ? $clog2(NUM_CARS) : 1;

   logic [PENALTY_W-1:0]  penalty_ff, penalty_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_data_ff, rsp_data_in;

   logic                  fin_valid;
   logic                  fin_ready;
   rsp_type               fin_data;

   logic                  rd_en;
   logic [IDX_BITS-1:0]   rd_addr;
   car_flags_type         rd_flags;
   logic [FLOOR_BITS-1:0] rd_floor;
   logic [LOAD_BITS-1:0]  rd_load;
   logic                  wr_en;
   logic [IDX_BITS-1:0]   wr_addr;
   car_flags_type         wr_flags;
   logic [FLOOR_BITS-1:0] wr_floor;
   logic [LOAD_BITS-1:0]  wr_load;

   assign csr_ready = 1'b1;
   assign fin_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      penalty_in = penalty_ff;
      if (csr_valid && csr_ready) begin
         penalty_in = csr_data;
      end
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (fin_valid && fin_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = fin_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         penalty_ff   <= PENALTY_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         penalty_ff   <= penalty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   elgd_ctrl #(
      .NUM_CARS   (NUM_CARS),
      .FLOOR_BITS (FLOOR_BITS),
      .LOAD_BITS  (LOAD_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .penalty    (penalty_ff),
      .fin_valid  (fin_valid),
      .fin_ready  (fin_ready),
      .fin_data   (fin_data),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_flags   (rd_flags),
      .rd_floor   (rd_floor),
      .rd_load    (rd_load),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_flags   (wr_flags),
      .wr_floor   (wr_floor),
      .wr_load    (wr_load)
   );

   elgd_car_table #(
      .NUM_CARS   (NUM_CARS),
      .FLOOR_BITS (FLOOR_BITS),
      .LOAD_BITS  (LOAD_BITS)
   ) u_table (
      .clock      (clock),
      .reset      (reset),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_flags   (rd_flags),
      .rd_floor   (rd_floor),
      .rd_load    (rd_load),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_flags   (wr_flags),
      .wr_floor   (wr_floor),
      .wr_load    (wr_load)
   );

endmodule

// ----- tb/tb_elevator_group_dispatcher_unit.sv -----
`timescale 1ns / 1ps

module tb_elevator_group_dispatcher_unit;
   import elgd_pkg::*;

   localparam int CARS = NUM_CARS_DEF;
   localparam int FLOOR_TOP = (1 << FLOOR_BITS_DEF) - 1;
   localparam int LOAD_CEIL = (1 << LOAD_BITS_DEF) - 1;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [1:0] ACT_NONE = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   req_type req_data = '0;
   logic req_ready;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic [PENALTY_W-1:0] csr_data = '0;
   logic csr_ready;

   // Shadow car table, updated at each accepted beat
   bit known_q[CARS];
   logic [FLOOR_BITS_DEF-1:0] floor_q[CARS];
   bit faulty_q[CARS];
   bit motion_q[CARS];
   bit dirk_q[CARS];
   bit dirup_q[CARS];
   int unsigned load_q[CARS];
   logic [PENALTY_W-1:0] penalty_q = PENALTY_RESET;

   rsp_type dispatch_outcomes[$];
   int mismatches = 0;
   int cycle_count = 0;
   int stall_left = 0;
   bit idle_on = 1'b1;

   elevator_group_dispatcher_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_elevator_group_dispatcher_unit NOT OK");
         $finish;
      end
   end

   // Receiver stalls in random bursts while idle_on is set
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 11);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   function automatic rsp_type compute_dispatch(req_type item);
      rsp_type outc;
      int id;
      int pick;
      int span;
      int best_load;
      int best_dist;
      bit found;
      outc = '0;
      id = int'(item.car_id);
      pick = 0;
      best_load = 0;
      best_dist = 0;
      found = 1'b0;
      case (item.action)
         ACT_STATUS: begin
            if (known_q[id]) begin
               if (floor_q[id] != item.floor) begin
                  motion_q[id] = 1'b1;
               end else if (motion_q[id]) begin
                  motion_q[id] = 1'b0;
                  outc.reached = 1'b1;
               end
            end
            known_q[id] = 1'b1;
            floor_q[id] = item.floor;
            outc.car_moving = motion_q[id];
         end
         ACT_FAULT: begin
            faulty_q[id] = 1'b1;
            outc.car_moving = motion_q[id];
         end
         ACT_REQUEST: begin
            for (int c = 0; c < CARS; c++) begin
               if (known_q[c] && !faulty_q[c]) begin
                  span = int'(floor_q[c]) - int'(item.floor);
                  if (span < 0) span = -span;
                  // opposite last direction costs extra; unknown direction is free
                  if (dirk_q[c] && dirup_q[c] != item.going_up) span += int'(penalty_q);
                  if (!found || int'(load_q[c]) < best_load ||
                      (int'(load_q[c]) == best_load && span < best_dist)) begin
                     found = 1'b1;
                     pick = c;
                     best_load = int'(load_q[c]);
                     best_dist = span;
                  end
               end
            end
            if (found) begin
               if (load_q[pick] < LOAD_CEIL) load_q[pick]++;
               dirk_q[pick] = 1'b1;
               dirup_q[pick] = item.going_up;
               outc.assign_found = 1'b1;
               outc.assigned_car = pick[2:0];
            end
         end
         default: ;
      endcase
      return outc;
   endfunction

   function automatic int faulty_cars();
      int n;
      n = 0;
      for (int c = 0; c < CARS; c++) n += int'(faulty_q[c]);
      return n;
   endfunction

   task automatic report_mismatch(string what, rsp_type want, rsp_type got);
      mismatches++;
      if (mismatches <= 10)
         $display("%s @%0d: exp f=%0d c=%0d r=%0d m=%0d got f=%0d c=%0d r=%0d m=%0d",
                  what, cycle_count, want.assign_found, want.assigned_car, want.reached,
                  want.car_moving, got.assign_found, got.assigned_car, got.reached,
                  got.car_moving);
   endtask

   always @(posedge clock) begin : check_outcomes
      rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (dispatch_outcomes.size() == 0) begin
            report_mismatch("unexpected result beat", '0, rsp_data);
         end else begin
            want = dispatch_outcomes.pop_front();
            if (rsp_data.assign_found !== want.assign_found ||
                rsp_data.assigned_car !== want.assigned_car ||
                rsp_data.reached !== want.reached ||
                rsp_data.car_moving !== want.car_moving)
               report_mismatch("result mismatch", want, rsp_data);
         end
      end
   end

   task automatic send_beat(logic [1:0] act, int car, int flr, bit up);
      req_type item;
      int gap;
      item.action = act;
      item.car_id = car[2:0];
      item.floor = flr[FLOOR_BITS_DEF-1:0];
      item.going_up = up;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 12);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (req_ready !== 1'b1);
      dispatch_outcomes.push_back(compute_dispatch(item));
   endtask

   // Drop valid and wait until every outstanding result has come back
   task automatic settle_idle();
      req_valid <= 1'b0;
      while (dispatch_outcomes.size() != 0) @(posedge clock);
   endtask

   task automatic write_penalty(logic [PENALTY_W-1:0] value);
      settle_idle();
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      penalty_q = value;
   endtask

   task automatic send_random_beat();
      int r;
      int car;
      int flr;
      r = $urandom_range(0, 99);
      car = $urandom_range(0, CARS - 1);
      flr = $urandom_range(0, FLOOR_TOP);
      if (r < 46) begin
         // repeat the known floor half the time so moving cars come to rest
         if (known_q[car] && $urandom_range(0, 1)) flr = int'(floor_q[car]);
         send_beat(ACT_STATUS, car, flr, 1'($urandom_range(0, 1)));
      end else if (r < 92) begin
         send_beat(ACT_REQUEST, car, flr, 1'($urandom_range(0, 1)));
      end else if (r < 94 && faulty_cars() < 4) begin
         send_beat(ACT_FAULT, car, flr, 1'($urandom_range(0, 1)));
      end else begin
         send_beat(ACT_NONE, car, flr, 1'($urandom_range(0, 1)));
      end
   endtask

   task automatic test_empty_table();
      send_beat(ACT_REQUEST, 0, 0, 1'b1);
      send_beat(ACT_REQUEST, 5, FLOOR_TOP, 1'b0);
      send_beat(ACT_NONE, 7, FLOOR_TOP, 1'b1);
      send_beat(ACT_NONE, 0, 0, 1'b0);
   endtask

   task automatic test_status_motion();
      send_beat(ACT_STATUS, 0, 0, 1'b0);
      send_beat(ACT_STATUS, 7, FLOOR_TOP, 1'b1);
      send_beat(ACT_STATUS, 0, 5, 1'b0);
      send_beat(ACT_STATUS, 0, 5, 1'b0);
      send_beat(ACT_STATUS, 0, 5, 1'b1);
      send_beat(ACT_STATUS, 7, FLOOR_TOP, 1'b0);
   endtask

   task automatic test_hall_requests();
      send_beat(ACT_REQUEST, 0, FLOOR_TOP, 1'b1);
      send_beat(ACT_REQUEST, 7, 0, 1'b0);
      send_beat(ACT_REQUEST, 3, FLOOR_TOP, 1'b0);
      send_beat(ACT_REQUEST, 2, 32, 1'b1);
      send_beat(ACT_REQUEST, 0, 0, 1'b1);
   endtask

   task automatic test_fault_reports();
      send_beat(ACT_FAULT, 7, 0, 1'b0);
      send_beat(ACT_FAULT, 3, FLOOR_TOP, 1'b1);
      send_beat(ACT_STATUS, 7, 10, 1'b0);
      send_beat(ACT_STATUS, 7, 10, 1'b0);
      send_beat(ACT_REQUEST, 4, 10, 1'b1);
   endtask

   task automatic test_random_traffic();
      logic [PENALTY_W-1:0] settings[5];
      settings = '{4'd0, 4'd15, 4'd9, 4'd2, 4'd1};
      settings[2] = PENALTY_W'($urandom_range(3, 14));
      for (int phase = 0; phase < 5; phase++) begin
         write_penalty(settings[phase]);
         // one phase runs with no idling at all
         idle_on = (phase != 2);
         repeat (170) send_random_beat();
      end
   endtask

   task automatic test_load_saturation();
      int survivor;
      int count;
      survivor = -1;
      idle_on = 1'b0;
      for (int c = 0; c < CARS; c++)
         if (!faulty_q[c] && survivor < 0) survivor = c;
      for (int c = 0; c < CARS; c++)
         if (c != survivor && !faulty_q[c]) send_beat(ACT_FAULT, c, 0, 1'b0);
      send_beat(ACT_STATUS, survivor, $urandom_range(0, FLOOR_TOP), 1'b0);
      count = LOAD_CEIL + 4 - int'(load_q[survivor]);
      repeat (count)
         send_beat(ACT_REQUEST, 0, $urandom_range(0, FLOOR_TOP),
                   1'($urandom_range(0, 1)));
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_empty_table();
      test_status_motion();
      test_hall_requests();
      test_fault_reports();
      test_random_traffic();
      test_load_saturation();
      settle_idle();
      repeat (2 * CARS + 8) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb_elevator_group_dispatcher_unit OK");
      end else begin
         $display("tb_elevator_group_dispatcher_unit NOT OK");
      end
      $finish;
   end

endmodule
